// File: hdl/fixed_partition_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Fixed partition allocator assertion macros
// Shorthand for clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_PARTITION_ALLOCATOR_UNIT_MACROS_SVH

// Check a property at every rising edge of clk_i outside reset
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define FPA_ASSERT_NEXT(lbl, pre, post, msg) \
  `FPA_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// File: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed partition allocator package
// Shared constants, codes and transaction types of the allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Default geometry of the partition table
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Totals are 20 bits and saturate at their maximum
  localparam int                 TOTAL_W   = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

  // Configuration port
  localparam int                    CFG_IDX_W    = 4;
  localparam int                    CFG_DATA_W   = 8;
  localparam logic [CFG_IDX_W-1:0]  CFG_POLICY   = 4'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_BLOCKS   = 4'd1;
  localparam logic [1:0]            POLICY_RESET = 2'd0;
  localparam logic [4:0]            BLOCKS_RESET = 5'd16;

  // Transaction kinds
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_REQUEST = 2'd2
  } fpa_kind_e;

  // Allocation policies; the spare code behaves as first fit
  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } fpa_policy_e;

  // Input transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  block_slot;
    logic [15:0] amount;
  } fpa_in_t;

  // Result transaction
  typedef struct packed {
    logic               granted;
    logic [3:0]         chosen_block;
    logic [TOTAL_W-1:0] internal_total;
    logic [TOTAL_W-1:0] unallocated_total;
  } fpa_out_t;

  // Control part of the packet that walks the cell row
  typedef struct packed {
    logic       live;
    logic [1:0] kind;
    logic [3:0] slot;
    logic       found;
  } fpa_scan_t;

endpackage

// File: hdl/fpa_cell.sv
// ----------------------------------------------------------------------------
// Fixed partition allocator cell
// Holds one partition (size and free mark) and updates the scan packet that
// passes through it on its way to the next cell.
// ----------------------------------------------------------------------------
module fpa_cell #(
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5,
  parameter int CELL_IDX  = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  policy_i,
  input  logic [CNT_W-1:0]            active_cnt_i,
  input  logic                        clear_en_i,
  input  logic [IDX_W-1:0]            clear_idx_i,
  input  fpa_pkg::fpa_scan_t          ctl_i,
  input  logic [SIZE_BITS-1:0]        amount_i,
  input  logic [SIZE_BITS-1:0]        best_i,
  input  logic [IDX_W-1:0]            pick_i,
  input  logic [fpa_pkg::TOTAL_W-1:0] sum_i,
  output fpa_pkg::fpa_scan_t          ctl_o,
  output logic [SIZE_BITS-1:0]        amount_o,
  output logic [SIZE_BITS-1:0]        best_o,
  output logic [IDX_W-1:0]            pick_o,
  output logic [fpa_pkg::TOTAL_W-1:0] sum_o
);

  localparam int AW = ((SIZE_BITS > fpa_pkg::TOTAL_W) ? SIZE_BITS : fpa_pkg::TOTAL_W) + 1;

  logic [SIZE_BITS-1:0]        size_q, size_d;
  logic                        free_q, free_d;
  fpa_pkg::fpa_scan_t          ctl_q, ctl_d;
  logic [SIZE_BITS-1:0]        amount_q, best_q, best_d;
  logic [IDX_W-1:0]            pick_q, pick_d;
  logic [fpa_pkg::TOTAL_W-1:0] sum_q, sum_d;
  logic                        in_range, slot_hit, fits, take;
  logic [AW-1:0]               sum_ext;
  logic [fpa_pkg::TOTAL_W-1:0] sum_sat;

  // Decode this cell's place against the packet and the configuration
  assign in_range = CNT_W'(CELL_IDX) < active_cnt_i;
  assign slot_hit = 32'(ctl_i.slot) == 32'(CELL_IDX);
  assign fits     = in_range && free_q && (size_q >= amount_i);

  // Add this partition to the running capacity, saturating
  assign sum_ext = AW'(sum_i) + AW'(size_q);
  assign sum_sat = (sum_ext > AW'(fpa_pkg::TOTAL_MAX)) ? fpa_pkg::TOTAL_MAX
                                                        : fpa_pkg::TOTAL_W'(sum_ext);

  // Apply the packet to this partition and update the candidate
  always_comb begin
    ctl_d  = ctl_i;
    best_d = best_i;
    pick_d = pick_i;
    sum_d  = sum_i;
    size_d = size_q;
    free_d = free_q;
    take   = 1'b0;
    if (ctl_i.live) begin
      case (ctl_i.kind)
        fpa_pkg::KIND_LOAD: begin
          if (slot_hit) begin
            size_d = amount_i;
          end
        end
        fpa_pkg::KIND_RESTART: begin
          free_d = in_range;
          if (in_range) begin
            sum_d = sum_sat;
          end
        end
        fpa_pkg::KIND_REQUEST: begin
          case (policy_i)
            fpa_pkg::POL_BEST:  take = fits && (!ctl_i.found || (size_q < best_i));
            fpa_pkg::POL_WORST: take = fits && (!ctl_i.found || (size_q > best_i));
            default:            take = fits && !ctl_i.found;
          endcase
        end
        default: ;
      endcase
    end
    if (take) begin
      ctl_d.found = 1'b1;
      best_d      = size_q;
      pick_d      = IDX_W'(CELL_IDX);
    end
    // Mark the granted partition used
    if (clear_en_i && (clear_idx_i == IDX_W'(CELL_IDX))) begin
      free_d = 1'b0;
    end
  end

  // Control state: packet control fields and free mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      free_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_d;
      free_q <= free_d;
    end
  end

  // Payload: partition size and packet data
  always_ff @(posedge clk_i) begin
    size_q   <= size_d;
    amount_q <= amount_i;
    best_q   <= best_d;
    pick_q   <= pick_d;
    sum_q    <= sum_d;
  end

  assign ctl_o    = ctl_q;
  assign amount_o = amount_q;
  assign best_o   = best_q;
  assign pick_o   = pick_q;
  assign sum_o    = sum_q;

endmodule

// File: hdl/fixed_partition_allocator_unit.sv
// ----------------------------------------------------------------------------
// Fixed partition allocator
// First, best or worst fit allocation over a row of partition cells.
// ----------------------------------------------------------------------------
// Flow: a taken transaction is held in the launch register, then walks the cell
// row one partition per cycle and waits in the pending register until the output
// register is free. A new transaction is taken only once the last result has
// moved on; a stalled result holds the next result in the pending register.
// Reset: all partitions not free, totals zero, policy first fit, 16 blocks in use;
// partition sizes are undefined until loaded.
module fixed_partition_allocator_unit #(
  parameter int NUM_BLOCKS = fpa_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fpa_pkg::fpa_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fpa_pkg::fpa_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int AW    = ((SIZE_BITS > fpa_pkg::TOTAL_W) ? SIZE_BITS : fpa_pkg::TOTAL_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PEND
  } state_e;

  state_e                      state_q, state_d;
  logic                        out_valid_q, out_valid_d;
  logic                        launch_live_q, launch_live_d;
  logic [1:0]                  policy_q, policy_d;
  logic [4:0]                  blocks_q, blocks_d;
  logic [fpa_pkg::TOTAL_W-1:0] frag_q, frag_d, space_q, space_d;
  logic                        pend_load, out_load, clear_en, grant;
  fpa_pkg::fpa_out_t           pend_q, pend_d, out_q;
  logic [1:0]                  launch_kind_q;
  logic [3:0]                  launch_slot_q;
  logic [SIZE_BITS-1:0]        launch_amount_q;
  logic [CNT_W-1:0]            active_cnt;

  // Cell row links; entry 0 is the launch register
  fpa_pkg::fpa_scan_t          chain_ctl    [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0]        chain_amount [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0]        chain_best   [NUM_BLOCKS+1];
  logic [IDX_W-1:0]            chain_pick   [NUM_BLOCKS+1];
  logic [fpa_pkg::TOTAL_W-1:0] chain_sum    [NUM_BLOCKS+1];

  logic [SIZE_BITS-1:0]        frag_add;
  logic [AW-1:0]               frag_ext;
  logic [fpa_pkg::TOTAL_W-1:0] frag_sat, space_sub;

  // Clamp the configured partition count to the table
  assign active_cnt = (32'(blocks_q) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                         : CNT_W'(blocks_q);

  // Launch a fresh packet into the first cell
  assign chain_ctl[0]    = {launch_live_q, launch_kind_q, launch_slot_q, 1'b0};
  assign chain_amount[0] = launch_amount_q;
  assign chain_best[0]   = '0;
  assign chain_pick[0]   = '0;
  assign chain_sum[0]    = '0;

  // Row of partition cells
  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    fpa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .policy_i     (policy_q),
      .active_cnt_i (active_cnt),
      .clear_en_i   (clear_en),
      .clear_idx_i  (chain_pick[NUM_BLOCKS]),
      .ctl_i        (chain_ctl[g]),
      .amount_i     (chain_amount[g]),
      .best_i       (chain_best[g]),
      .pick_i       (chain_pick[g]),
      .sum_i        (chain_sum[g]),
      .ctl_o        (chain_ctl[g+1]),
      .amount_o     (chain_amount[g+1]),
      .best_o       (chain_best[g+1]),
      .pick_o       (chain_pick[g+1]),
      .sum_o        (chain_sum[g+1])
    );
  end

  // Total updates for the packet leaving the row
  assign grant     = (chain_ctl[NUM_BLOCKS].kind == fpa_pkg::KIND_REQUEST) &&
                     chain_ctl[NUM_BLOCKS].found;
  assign frag_add  = chain_best[NUM_BLOCKS] - chain_amount[NUM_BLOCKS];
  assign frag_ext  = AW'(frag_q) + AW'(frag_add);
  assign frag_sat  = (frag_ext > AW'(fpa_pkg::TOTAL_MAX)) ? fpa_pkg::TOTAL_MAX
                                                          : fpa_pkg::TOTAL_W'(frag_ext);
  assign space_sub = (AW'(space_q) > AW'(chain_amount[NUM_BLOCKS]))
                     ? fpa_pkg::TOTAL_W'(AW'(space_q) - AW'(chain_amount[NUM_BLOCKS]))
                     : '0;

  // Sequencer, configuration and totals
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    launch_live_d = 1'b0;
    policy_d      = policy_q;
    blocks_d      = blocks_q;
    frag_d        = frag_q;
    space_d       = space_q;
    pend_load     = 1'b0;
    out_load      = 1'b0;
    clear_en      = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fpa_pkg::CFG_POLICY: policy_d = cfg_data_i[1:0];
        fpa_pkg::CFG_BLOCKS: blocks_d = cfg_data_i[4:0];
        default: ;
      endcase
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          launch_live_d = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain_ctl[NUM_BLOCKS].live) begin
          pend_load = 1'b1;
          state_d   = S_PEND;
          if (chain_ctl[NUM_BLOCKS].kind == fpa_pkg::KIND_RESTART) begin
            frag_d  = '0;
            space_d = chain_sum[NUM_BLOCKS];
          end else if (grant) begin
            frag_d   = frag_sat;
            space_d  = space_sub;
            clear_en = 1'b1;
          end
        end
      end
      S_PEND: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Build the result from the totals after the update
  always_comb begin
    pend_d                   = '0;
    pend_d.granted           = grant;
    pend_d.chosen_block      = grant ? 4'(chain_pick[NUM_BLOCKS]) : 4'd0;
    pend_d.internal_total    = frag_d;
    pend_d.unallocated_total = space_d;
  end

  // Hold state, valid flags, configuration and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      launch_live_q <= 1'b0;
      policy_q      <= fpa_pkg::POLICY_RESET;
      blocks_q      <= fpa_pkg::BLOCKS_RESET;
      frag_q        <= '0;
      space_q       <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      launch_live_q <= launch_live_d;
      policy_q      <= policy_d;
      blocks_q      <= blocks_d;
      frag_q        <= frag_d;
      space_q       <= space_d;
    end
  end

  // Capture the launched transaction and the result payloads
  always_ff @(posedge clk_i) begin
    if (launch_live_d) begin
      launch_kind_q   <= in_data_i.kind;
      launch_slot_q   <= in_data_i.block_slot;
      launch_amount_q <= SIZE_BITS'(in_data_i.amount);
    end
    if (pend_load) begin
      pend_q <= pend_d;
    end
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// File: hdl/fpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed partition allocator checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_partition_allocator_unit_macros.svh"

module fpa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fpa_pkg::fpa_out_t out_data_o
);

  // Hold a stalled result transaction
  `FPA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Refused requests report partition zero
  `FPA_ASSERT(a_refused_zero, (out_valid_o && !out_data_o.granted) |-> (out_data_o.chosen_block == 4'd0), "refused result names a partition")

  // Take one transaction at a time
  `FPA_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken while busy")

  // Never present a new result in the cycle after taking a transaction
  `FPA_ASSERT_NEXT(a_no_instant_result, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o, "result appeared without a scan")

endmodule

bind fixed_partition_allocator_unit fpa_checker u_fpa_checker (.*);

// File: dv/tb_fixed_partition_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed partition allocator testbench
// Drives load, restart, request and spare transactions through the allocator
// under every fit policy and a range of partition counts, predicts each result
// with a cycle-free allocation model and compares results field by field.
// ----------------------------------------------------------------------------

// Allocation predictor and result store
class alloc_scoreboard;
  logic [15:0]       size_tab [16];
  bit                free_tab [16];
  logic [19:0]       frag_sum;
  logic [19:0]       space_sum;
  logic [1:0]        policy_code;
  logic [4:0]        blocks_cfg;
  fpa_pkg::fpa_out_t expected_q [$];
  int                mismatches;
  int                checked;
  int                grants;
  int                noted;

  function new();
    for (int i = 0; i < 16; i++) begin
      size_tab[i] = '0;
      free_tab[i] = 1'b0;
    end
    frag_sum    = '0;
    space_sum   = '0;
    policy_code = fpa_pkg::POLICY_RESET;
    blocks_cfg  = fpa_pkg::BLOCKS_RESET;
    mismatches  = 0;
    checked     = 0;
    grants      = 0;
    noted       = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Mirror a register write
  function void set_reg(logic [fpa_pkg::CFG_IDX_W-1:0] idx,
                        logic [fpa_pkg::CFG_DATA_W-1:0] val);
    if (idx == fpa_pkg::CFG_POLICY) begin
      policy_code = val[1:0];
    end else if (idx == fpa_pkg::CFG_BLOCKS) begin
      blocks_cfg = val[4:0];
    end
  endfunction

  // Apply one accepted transaction and queue the result it causes
  function void note_item(fpa_pkg::fpa_in_t it);
    int                 active;
    int                 pick;
    bit                 found;
    int                 total;
    logic [20:0]        frag_next;
    fpa_pkg::fpa_out_t  res;
    active = (blocks_cfg > 16) ? 16 : int'(blocks_cfg);
    found  = 1'b0;
    pick   = 0;
    noted++;
    case (it.kind)
      fpa_pkg::KIND_LOAD: begin
        size_tab[it.block_slot] = it.amount;
      end
      fpa_pkg::KIND_RESTART: begin
        total = 0;
        for (int i = 0; i < 16; i++) begin
          free_tab[i] = (i < active);
          if (i < active) total += size_tab[i];
        end
        frag_sum  = '0;
        space_sum = (total > int'(fpa_pkg::TOTAL_MAX)) ? fpa_pkg::TOTAL_MAX : total[19:0];
      end
      fpa_pkg::KIND_REQUEST: begin
        // scan in index order; the spare policy code stops at the first fit
        for (int i = 0; i < active; i++) begin
          if (!free_tab[i] || size_tab[i] < it.amount) continue;
          if (!found) begin
            found = 1'b1;
            pick  = i;
            if (policy_code != fpa_pkg::POL_BEST && policy_code != fpa_pkg::POL_WORST) break;
          end else if (policy_code == fpa_pkg::POL_BEST && size_tab[i] < size_tab[pick]) begin
            pick = i;
          end else if (policy_code == fpa_pkg::POL_WORST && size_tab[i] > size_tab[pick]) begin
            pick = i;
          end
        end
        if (found) begin
          free_tab[pick] = 1'b0;
          frag_next = {1'b0, frag_sum} + (size_tab[pick] - it.amount);
          frag_sum  = frag_next[20] ? fpa_pkg::TOTAL_MAX : frag_next[19:0];
          space_sum = (space_sum > it.amount) ? space_sum - it.amount : '0;
          grants++;
        end
      end
      default: ;
    endcase
    res.granted           = found;
    res.chosen_block      = found ? pick[3:0] : 4'd0;
    res.internal_total    = frag_sum;
    res.unallocated_total = space_sum;
    expected_q.push_back(res);
  endfunction

  // Compare one accepted result against the oldest expectation
  function void check_result(fpa_pkg::fpa_out_t got);
    fpa_pkg::fpa_out_t want;
    checked++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result: granted=%0d block=%0d internal=%0d unalloc=%0d",
                 $time, got.granted, got.chosen_block, got.internal_total,
                 got.unallocated_total);
      return;
    end
    want = expected_q.pop_front();
    if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
        got.internal_total !== want.internal_total ||
        got.unallocated_total !== want.unallocated_total) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: expected granted=%0d block=%0d internal=%0d unalloc=%0d",
                 $time, want.granted, want.chosen_block, want.internal_total,
                 want.unallocated_total);
        $display("[%0t]           got      granted=%0d block=%0d internal=%0d unalloc=%0d",
                 $time, got.granted, got.chosen_block, got.internal_total,
                 got.unallocated_total);
      end
    end
  endfunction
endclass

module tb_fixed_partition_allocator_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 400;

  // Kind code outside the defined set
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  fpa_pkg::fpa_in_t               in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  fpa_pkg::fpa_out_t              out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  alloc_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int cycle_count    = 0;
  int sent_count     = 0;

  // Policy and partition count of each random phase, extremes included
  int policy_seq [PHASES] = '{1, 2, 3, 0, 2, 1, 0, 2, 1};
  int blocks_seq [PHASES] = '{16, 1, 16, 8, 0, 31, 17, 16, 5};

  fixed_partition_allocator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock
  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL fixed_partition_allocator_unit");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(input fpa_pkg::fpa_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    sent_count++;
  endtask

  task automatic send_fields(input fpa_pkg::fpa_kind_e kind, input logic [3:0] slot,
                             input logic [15:0] amt);
    fpa_pkg::fpa_in_t it;
    it.kind       = kind;
    it.block_slot = slot;
    it.amount     = amt;
    send_item(it);
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fpa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpa_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Partition size mix: empty, full, small and anything
  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r < 4) return 16'($urandom_range(255));
    return 16'($urandom_range(65535));
  endfunction

  // Request size: mostly one that some partition can hold
  function automatic logic [15:0] pick_request();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 16'($urandom_range(int'(sb.size_tab[$urandom_range(15)])));
    if (r == 6) return 16'd0;
    if (r == 7) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  // One allocation round: reload some sizes, usually restart, then a run of requests
  task automatic run_round();
    fpa_pkg::fpa_in_t junk;
    int               n_load;
    int               n_req;
    n_load = $urandom_range(3);
    n_req  = $urandom_range(2, 12);
    repeat (n_load) send_fields(fpa_pkg::KIND_LOAD, 4'($urandom_range(15)), pick_size());
    if ($urandom_range(9) != 0)
      send_fields(fpa_pkg::KIND_RESTART, 4'($urandom_range(15)), 16'($urandom_range(65535)));
    repeat (n_req) begin
      if ($urandom_range(19) == 0) begin
        // noise: spare kind code or a stray load in the middle of a round
        junk.kind       = ($urandom_range(1) != 0) ? KIND_SPARE : fpa_pkg::KIND_LOAD;
        junk.block_slot = 4'($urandom_range(15));
        junk.amount     = pick_size();
        send_item(junk);
      end
      send_fields(fpa_pkg::KIND_REQUEST, 4'($urandom_range(15)), pick_request());
    end
  endtask

  // Stimulus
  initial begin
    logic [15:0]      dir_sizes [16];
    fpa_pkg::fpa_in_t spare;
    int               target;
    dir_sizes = '{16'hFFFF, 16'd0, 16'd100, 16'd300, 16'd200, 16'h8000, 16'd50, 16'hFFFF,
                  16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128};
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: load every partition, then probe the special cases
    for (int i = 0; i < 16; i++) send_fields(fpa_pkg::KIND_LOAD, 4'(i), dir_sizes[i]);
    send_fields(fpa_pkg::KIND_REQUEST, 4'd0, 16'd0);     // nothing free before restart
    spare.kind       = KIND_SPARE;
    spare.block_slot = 4'hF;
    spare.amount     = 16'hFFFF;
    send_item(spare);                                    // spare kind has no effect
    send_fields(fpa_pkg::KIND_RESTART, 4'd0, 16'd0);
    send_fields(fpa_pkg::KIND_REQUEST, 4'd0, 16'd0);     // zero request fits anything
    send_fields(fpa_pkg::KIND_REQUEST, 4'd0, 16'hFFFF);  // exact fit on a full partition
    send_fields(fpa_pkg::KIND_REQUEST, 4'd0, 16'hFFFF);  // no fitting partition left
    send_fields(fpa_pkg::KIND_REQUEST, 4'd0, 16'd1);
    send_fields(fpa_pkg::KIND_REQUEST, 4'd0, 16'd0);     // empty partition fits zero
    send_fields(fpa_pkg::KIND_LOAD, 4'd3, 16'd77);       // load keeps the free mark
    send_fields(fpa_pkg::KIND_REQUEST, 4'd0, 16'd70);
    drain();

    // Random phases, each under its own register setting and idle profile
    for (int p = 0; p < PHASES; p++) begin
      write_reg(fpa_pkg::CFG_POLICY, 8'(policy_seq[p]));
      write_reg(fpa_pkg::CFG_BLOCKS, 8'(blocks_seq[p]));
      if (p < 3) begin
        send_idle_pct  = 6;
        recv_stall_pct = 57;
      end else if (p < 6) begin
        send_idle_pct  = 57;
        recv_stall_pct = 6;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (p == 1 || p == 6) hold_req = HOLD_CYCLES;
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) begin
        run_round();
        if (sent_count >= target - PHASE_ITEMS / 2 && sent_count < target - PHASE_ITEMS / 2 + 8)
          drain();
      end
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (fpa_pkg::NUM_BLOCKS_DEF * 3) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d results, %0d grants, %0d mismatches",
             sb.noted, sb.checked, sb.grants, sb.mismatches);
    $display("Covered first, best, worst and spare fit with 0 to 31 partitions in use");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS fixed_partition_allocator_unit");
    end else begin
      $display("FAIL fixed_partition_allocator_unit");
    end
    $finish;
  end

endmodule
